>>> rtl/core/trbba_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and a helper function of the two-region block allocator
package trbba_pkg;

	localparam int WORD_BITS = 64;
	localparam int OFF_W     = 6;
	localparam int BLK_W     = 12;
	localparam int TDATA_W   = 16;

	localparam logic [WORD_BITS-1:0] ONES_WORD  = '1;
	// blocks zero and one start reserved
	localparam logic [WORD_BITS-1:0] INIT_WORD0 = ~(WORD_BITS'(3));

	typedef enum logic [1:0] {
		RES_GRANT = 2'd0,
		RES_MISS  = 2'd1,
		RES_FREED = 2'd2
	} res_kind_t;

	typedef struct packed {
		logic      init_wr;
		logic      capture;
		logic      scan_rd;
		logic      free_rd;
		logic      alloc_wr;
		logic      free_wr;
		logic      out_ld;
		res_kind_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic init_last;
		logic req_free;
		logic hit;
		logic scan_end;
		logic rd_more;
		logic out_free;
	} status_t;

	// index of the single set bit of a one-hot word
	function automatic logic [OFF_W-1:0] onehot_index(input logic [WORD_BITS-1:0] oh);
		logic [OFF_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (oh[i]) begin
				idx = idx | OFF_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

>>> rtl/core/trbba_ctrl.sv
`timescale 1ns / 1ps
// controller state machine of the two-region block allocator
module trbba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  trbba_pkg::status_t st,
	output trbba_pkg::cmd_t    cmd
);
	import trbba_pkg::*;

	typedef enum logic [5:0] {
		ST_INIT     = 6'b000001,
		ST_IDLE     = 6'b000010,
		ST_SCAN     = 6'b000100,
		ST_ALLOC_WR = 6'b001000,
		ST_FREE_RD  = 6'b010000,
		ST_FREE_WR  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (st.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = st.req_free ? ST_FREE_RD : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (st.hit) begin
					state_d = ST_ALLOC_WR;
				end else if (st.scan_end) begin
					if (st.out_free) begin
						cmd.out_ld  = 1'b1;
						cmd.out_sel = RES_MISS;
						state_d     = ST_IDLE;
					end
				end else begin
					cmd.scan_rd = st.rd_more;
				end
			end
			ST_ALLOC_WR: begin
				if (st.out_free) begin
					cmd.alloc_wr = 1'b1;
					cmd.out_ld   = 1'b1;
					cmd.out_sel  = RES_GRANT;
					state_d      = ST_IDLE;
				end
			end
			ST_FREE_RD: begin
				cmd.free_rd = 1'b1;
				state_d     = ST_FREE_WR;
			end
			ST_FREE_WR: begin
				if (st.out_free) begin
					cmd.free_wr = 1'b1;
					cmd.out_ld  = 1'b1;
					cmd.out_sel = RES_FREED;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/trbba_dp.sv
`timescale 1ns / 1ps
// datapath of the two-region block allocator: bitmap memory, scan, search and result register
module trbba_dp #(
	parameter int TOTAL_BLOCKS = 4096,
	parameter int META_BLOCKS  = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [1:0]                      in_user,
	input  logic [trbba_pkg::TDATA_W-1:0]   in_data,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [trbba_pkg::TDATA_W-1:0]   out_data,
	output logic                            out_user,
	input  trbba_pkg::cmd_t                 cmd,
	output trbba_pkg::status_t              st
);
	import trbba_pkg::*;

	localparam int WORDS      = (TOTAL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PW         = $clog2(WORDS + 1);
	localparam int META_END   = (META_BLOCKS < TOTAL_BLOCKS) ? META_BLOCKS : TOTAL_BLOCKS;
	localparam int META_END_W = (META_END + WORD_BITS - 1) / WORD_BITS;
	localparam int DATA_LO_W  = META_END / WORD_BITS;
	localparam int META_HI_W  = META_END / WORD_BITS;
	localparam int META_HI_O  = META_END % WORD_BITS;
	localparam int DATA_LO_O  = META_END % WORD_BITS;
	localparam int DATA_HI_W  = TOTAL_BLOCKS / WORD_BITS;
	localparam int DATA_HI_O  = TOTAL_BLOCKS % WORD_BITS;

	logic [WORD_BITS-1:0] mem_q [WORDS];

	logic                 region_q;
	logic [BLK_W-1:0]     blk_q;
	logic [PW-1:0]        rd_ptr_q;
	logic [PW-1:0]        end_q;
	logic [AW-1:0]        init_ptr_q;
	logic                 rd_vld_s1;
	logic [AW-1:0]        addr_s1;
	logic [WORD_BITS-1:0] rdata_s1;

	logic                 out_valid_q;
	logic [BLK_W-1:0]     out_blk_q;
	logic                 out_found_q;

	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	logic [31:0]          blk32;
	logic [31:0]          fw32;
	logic [AW-1:0]        free_word;
	logic                 free_in_range;

	logic [PW-1:0]        lo_word;
	logic [PW-1:0]        hi_word;
	logic [OFF_W-1:0]     lo_off;
	logic [OFF_W-1:0]     hi_off;
	logic [WORD_BITS-1:0] masked;
	logic [WORD_BITS-1:0] lowest;
	logic [OFF_W-1:0]     hit_off;
	logic [31:0]          grant32;

	// free request decode
	assign blk32         = 32'(blk_q);
	assign fw32          = blk32 >> OFF_W;
	assign free_word     = fw32[AW-1:0];
	assign free_in_range = (blk32 < 32'(TOTAL_BLOCKS));

	// region bounds in word and bit-offset form
	always_comb begin
		if (region_q) begin
			lo_word = PW'(DATA_LO_W);
			lo_off  = OFF_W'(DATA_LO_O);
			hi_word = PW'(DATA_HI_W);
			hi_off  = OFF_W'(DATA_HI_O);
		end else begin
			lo_word = '0;
			lo_off  = '0;
			hi_word = PW'(META_HI_W);
			hi_off  = OFF_W'(META_HI_O);
		end
	end

	// keep only the free bits of the fetched word that lie inside the region
	always_comb begin
		masked = rdata_s1;
		if (PW'(addr_s1) == lo_word) begin
			masked = masked & (ONES_WORD << lo_off);
		end
		if (PW'(addr_s1) == hi_word) begin
			masked = masked & ~(ONES_WORD << hi_off);
		end
	end

	assign lowest  = masked & (~masked + WORD_BITS'(1));
	assign hit_off = onehot_index(lowest);
	assign grant32 = 32'({addr_s1, hit_off});

	// memory ports
	assign rd_en   = cmd.scan_rd | cmd.free_rd;
	assign rd_addr = cmd.free_rd ? free_word : rd_ptr_q[AW-1:0];
	assign wr_en   = cmd.init_wr | cmd.alloc_wr | (cmd.free_wr & free_in_range);
	assign wr_addr = cmd.init_wr ? init_ptr_q : addr_s1;

	always_comb begin
		if (cmd.init_wr) begin
			wr_data = (init_ptr_q == '0) ? INIT_WORD0 : ONES_WORD;
		end else if (cmd.alloc_wr) begin
			wr_data = rdata_s1 & ~lowest;
		end else begin
			wr_data = rdata_s1 | (WORD_BITS'(1) << blk_q[OFF_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
			addr_s1  <= rd_addr;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			region_q <= in_user[1];
			blk_q    <= in_data[BLK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			end_q      <= '0;
			init_ptr_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.init_wr) begin
				init_ptr_q <= init_ptr_q + AW'(1);
			end
			if (cmd.capture) begin
				rd_ptr_q <= in_user[1] ? PW'(DATA_LO_W) : '0;
				end_q    <= in_user[1] ? PW'(WORDS) : PW'(META_END_W);
			end else if (cmd.scan_rd) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			case (cmd.out_sel)
				RES_GRANT: begin
					out_blk_q   <= grant32[BLK_W-1:0];
					out_found_q <= 1'b1;
				end
				RES_FREED: begin
					out_blk_q   <= '0;
					out_found_q <= 1'b1;
				end
				default: begin
					out_blk_q   <= '0;
					out_found_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = TDATA_W'(out_blk_q);
	assign out_user  = out_found_q;

	// status back to the controller
	assign st.init_last = (init_ptr_q == AW'(WORDS - 1));
	assign st.req_free  = in_user[0];
	assign st.rd_more   = (rd_ptr_q < end_q);
	assign st.hit       = rd_vld_s1 & (|masked);
	assign st.scan_end  = ~(rd_ptr_q < end_q) & ~rd_vld_s1;
	assign st.out_free  = ~out_valid_q | out_ready;

endmodule

>>> rtl/core/two_region_bitmap_block_allocator_top.sv
`timescale 1ns / 1ps
// top level of the two-region first-fit bitmap block allocator
//
// channel | direction | signals                     | content
// --------+-----------+-----------------------------+-----------------------------------------
// s       | in        | s_tvalid s_tready s_tdata   | request item: tuser kind and region,
//         |           | s_tuser                     | tdata block number to free
// m       | out       | m_tvalid m_tready m_tdata   | result item: tdata granted block,
//         |           | m_tuser                     | tuser found flag
//
// after reset the bitmap is written one 64-bit word a cycle, during which s_tready stays low
// an allocate reads one bitmap word a cycle from the start of its region through the single
// memory read port, up to the hit or the end of the region
// a free is a read-modify-write of one word
// one request is in flight at a time; a new item is accepted while the previous result still
// waits in the output register, and a result waiting for m_tready holds back the next one
module two_region_bitmap_block_allocator_top #(
	parameter int TOTAL_BLOCKS = 4096,
	parameter int META_BLOCKS  = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [trbba_pkg::TDATA_W-1:0] s_tdata,  // [11:0] block_number, rest zero
	input  logic [1:0]                    s_tuser,  // [0] req_type, [1] region
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [trbba_pkg::TDATA_W-1:0] m_tdata,  // [11:0] granted_block, rest zero
	output logic                          m_tuser   // [0] found
);
	import trbba_pkg::*;

	cmd_t    cmd;
	status_t st;

	// sequencing of init sweep, region scan and bitmap updates
	trbba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// bitmap memory, masking and lowest-free search, result register
	trbba_dp #(
		.TOTAL_BLOCKS (TOTAL_BLOCKS),
		.META_BLOCKS  (META_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_user   (s_tuser),
		.in_data   (s_tdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for the two-region block allocator: directed, region-fill and random traffic
module tb;
	import trbba_pkg::*;

	localparam int TOTAL_BLOCKS = 4096;
	localparam int META_BLOCKS  = 128;
	// metadata region is clipped to the disk
	localparam int META_END     = (META_BLOCKS < TOTAL_BLOCKS) ? META_BLOCKS : TOTAL_BLOCKS;
	localparam int IDLE_PCT     = 35;
	localparam int RANDOM_ITEMS = 640;
	localparam int DATA_BURST   = 150;
	// covers a full data scan together with receiver stalls
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 100;
	localparam int MAX_REPORTS  = 30;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_kind_e;

	typedef enum logic {
		REGION_META = 1'b0,
		REGION_DATA = 1'b1
	} region_e;

	typedef struct {
		logic [BLK_W-1:0] block;
		logic             found;
	} alloc_result_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;
	logic [1:0]         s_tuser  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;

	// no idling on either side while set
	bit steady = 1'b0;

	// bench copy of the free map and the results still owed by the block
	bit            free_map [TOTAL_BLOCKS];
	alloc_result_t owed_results [$];
	int unsigned   held_blocks [$];

	int grants;
	int misses;
	int frees;
	int mismatch_count;
	int quiet_cycles;

	two_region_bitmap_block_allocator_top #(
		.TOTAL_BLOCKS(TOTAL_BLOCKS),
		.META_BLOCKS (META_BLOCKS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #1 clk = ~clk;

	// receiver stalls at random unless in a steady stretch
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_REPORTS) begin
			$display("mismatch at %0t: %s", $time, what);
		end
		mismatch_count++;
	endtask

	function automatic void clear_free_map();
		foreach (free_map[i]) begin
			free_map[i] = 1'b1;
		end
		// blocks zero and one are reserved after reset
		free_map[0] = 1'b0;
		free_map[1] = 1'b0;
	endfunction

	function automatic int free_in_region(input region_e region);
		int lo;
		int hi;
		int count;
		lo    = (region == REGION_META) ? 0 : META_END;
		hi    = (region == REGION_META) ? META_END : TOTAL_BLOCKS;
		count = 0;
		for (int i = lo; i < hi; i++) begin
			count += free_map[i];
		end
		return count;
	endfunction

	// first-fit allocation or free on the bench map, giving the owed result
	function automatic alloc_result_t apply_request(input req_kind_e kind, input region_e region,
			input logic [BLK_W-1:0] blk);
		alloc_result_t res;
		int lo;
		int hi;
		res.block = '0;
		res.found = 1'b0;
		if (kind == REQ_FREE) begin
			// idempotent, and out-of-range numbers leave the map alone
			if (int'(blk) < TOTAL_BLOCKS) begin
				free_map[blk] = 1'b1;
			end
			res.found = 1'b1;
			frees++;
			return res;
		end
		lo = (region == REGION_META) ? 0 : META_END;
		hi = (region == REGION_META) ? META_END : TOTAL_BLOCKS;
		for (int i = lo; i < hi; i++) begin
			if (free_map[i]) begin
				free_map[i] = 1'b0;
				res.block   = BLK_W'(i);
				res.found   = 1'b1;
				held_blocks.push_back(i);
				grants++;
				return res;
			end
		end
		// region full: block zero, not found, map untouched
		misses++;
		return res;
	endfunction

	// drives one request item, waits for acceptance and records what it owes
	// called at a rising edge; leaves tvalid high so a following item can follow without a gap
	task automatic send_request(input req_kind_e kind, input region_e region,
			input logic [BLK_W-1:0] blk);
		bit taken;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(blk);
		s_tuser  <= {region, kind};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		owed_results.push_back(apply_request(kind, region, blk));
	endtask

	// stops sending and waits until every owed result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (owed_results.size() != 0);
	endtask

	// every result is checked against the oldest owed one
	always @(negedge clk) begin : result_check
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result: tdata %0d found %0b",
					m_tdata, m_tuser));
			end else begin
				want = owed_results.pop_front();
				if (m_tdata !== TDATA_W'(want.block)) begin
					report_mismatch($sformatf("granted block %0d, expected %0d",
						m_tdata, want.block));
				end
				if (m_tuser !== want.found) begin
					report_mismatch($sformatf("found flag %0b, expected %0b",
						m_tuser, want.found));
				end
			end
		end
	end

	// ends a run in which no item moves for too long
	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// field extremes, reserved blocks, repeated frees and ignored fields
	task automatic test_basic_requests();
		send_request(REQ_ALLOC, REGION_META, '0);       // lowest free metadata block, two
		send_request(REQ_ALLOC, REGION_DATA, '1);       // block field ignored on allocate
		send_request(REQ_ALLOC, REGION_META, '1);
		send_request(REQ_FREE,  REGION_DATA, 12'd2);    // region ignored on free
		send_request(REQ_FREE,  REGION_META, 12'd2);    // second free of the same block
		send_request(REQ_ALLOC, REGION_META, 12'h555);
		send_request(REQ_FREE,  REGION_META, 12'd0);    // reserved blocks freed like any other
		send_request(REQ_FREE,  REGION_DATA, 12'd1);
		send_request(REQ_ALLOC, REGION_META, 12'hAAA);  // hands out block zero
		send_request(REQ_ALLOC, REGION_META, '0);       // then block one
		send_request(REQ_ALLOC, REGION_META, '0);
		send_request(REQ_FREE,  REGION_META, '1);       // last block, already free
		send_request(REQ_FREE,  REGION_DATA, 12'hAAA);
		send_request(REQ_FREE,  REGION_META, 12'h555);
		send_request(REQ_FREE,  REGION_DATA, '0);
		send_request(REQ_FREE,  REGION_META, BLK_W'(META_END));
		send_request(REQ_ALLOC, REGION_DATA, '0);       // first data block again
		send_request(REQ_ALLOC, REGION_DATA, '0);
		send_request(REQ_ALLOC, REGION_DATA, '1);
	endtask

	// fill the metadata region, then miss, then reuse freed holes
	task automatic test_meta_region_full();
		while (free_in_region(REGION_META) > 0) begin
			send_request(REQ_ALLOC, REGION_META, BLK_W'($urandom));
		end
		send_request(REQ_ALLOC, REGION_META, '0);
		send_request(REQ_ALLOC, REGION_META, '1);
		send_request(REQ_ALLOC, REGION_DATA, '0);       // data region unaffected
		send_request(REQ_FREE,  REGION_META, 12'd77);
		send_request(REQ_FREE,  REGION_META, 12'd64);   // first block of the second word
		send_request(REQ_ALLOC, REGION_META, '0);
		send_request(REQ_ALLOC, REGION_META, '0);
		send_request(REQ_ALLOC, REGION_META, '0);
	endtask

	// back-to-back data allocations over several words, then holes on word edges reused
	task automatic test_data_word_edges();
		steady = 1'b1;
		for (int k = 0; k < DATA_BURST; k++) begin
			send_request(REQ_ALLOC, REGION_DATA, BLK_W'($urandom));
		end
		steady = 1'b0;
		// last block of a word, first block of the next one, and the last disk block
		send_request(REQ_FREE,  REGION_DATA, BLK_W'(META_END + 127));
		send_request(REQ_FREE,  REGION_META, BLK_W'(META_END + 64));
		send_request(REQ_FREE,  REGION_DATA, BLK_W'(META_END + 63));
		send_request(REQ_FREE,  REGION_META, BLK_W'(TOTAL_BLOCKS - 1));
		for (int k = 0; k < 5; k++) begin
			send_request(REQ_ALLOC, REGION_DATA, '0);
		end
	endtask

	// mostly allocations and frees of blocks handed out, with stray frees mixed in
	task automatic test_random_traffic(input int count);
		int pick;
		int idx;
		int blk;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				send_request(REQ_ALLOC, region_e'($urandom_range(1)), BLK_W'($urandom));
			end else if (pick < 75 && held_blocks.size() != 0) begin
				idx = $urandom_range(held_blocks.size() - 1);
				blk = held_blocks[idx];
				held_blocks.delete(idx);
				send_request(REQ_FREE, region_e'($urandom_range(1)), BLK_W'(blk));
			end else if (pick < 90) begin
				send_request(REQ_FREE, region_e'($urandom_range(1)),
					BLK_W'($urandom_range(META_END - 1)));
			end else begin
				send_request(REQ_FREE, region_e'($urandom_range(1)), BLK_W'($urandom));
			end
		end
	endtask

	initial begin
		clear_free_map();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_requests();
		test_meta_region_full();
		test_data_word_edges();
		// the sender holds off until every owed result is back
		wait_drained();
		test_random_traffic(RANDOM_ITEMS / 2);
		wait_drained();
		test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("requests checked: %0d grants, %0d region-full replies, %0d frees",
			grants, misses, frees);
		$display("metadata region filled, data allocated across word edges; %0d mismatches",
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> two_region_bitmap_block_allocator_top.f
rtl/core/trbba_pkg.sv
rtl/core/trbba_ctrl.sv
rtl/core/trbba_dp.sv
rtl/core/two_region_bitmap_block_allocator_top.sv
bench/tb.sv
